### hdl/modbus_meter_reply_parser_macros.svh
// Assertion macros for the checker file of the reply parser.
`ifndef MODBUS_METER_REPLY_PARSER_MACROS_SVH
`define MODBUS_METER_REPLY_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MMRP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MMRP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/mmrp_pkg.sv
// Constants and codes shared by the Modbus reply parser modules.
package mmrp_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // CSR register indexes
   localparam logic [1:0] CSR_DEV_ADDR   = 2'd0;
   localparam logic [1:0] CSR_FUNC_CODE  = 2'd1;
   localparam logic [1:0] CSR_COUNT_BYTE = 2'd2;

   localparam logic [7:0] DEV_ADDR_RST   = 8'h01;
   localparam logic [7:0] FUNC_CODE_RST  = 8'h03;
   localparam logic [7:0] COUNT_BYTE_RST = 8'h08;

   // byte positions within the nine-byte reply
   localparam logic [3:0] POS_ADDR   = 4'd0;
   localparam logic [3:0] POS_FUNC   = 4'd1;
   localparam logic [3:0] POS_COUNT  = 4'd2;
   localparam logic [3:0] POS_VOLT_H = 4'd3;
   localparam logic [3:0] POS_VOLT_L = 4'd4;
   localparam logic [3:0] POS_CURR_H = 4'd5;
   localparam logic [3:0] POS_CURR_L = 4'd6;
   localparam logic [3:0] POS_CRC_LO = 4'd7;
   localparam logic [3:0] POS_CRC_HI = 4'd8;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_CRC_BAD = 1'b1;

endpackage

### hdl/modbus_meter_reply_parser.sv
// Top level of the Modbus RTU meter reply parser: byte stage, frame logic, result stage.
//
//  channel  | ports                                   | transfer when
//  ---------+-----------------------------------------+-------------------------
//  req      | req_valid, req_ready, req_rx_byte        | req_valid & req_ready
//  rsp      | rsp_valid, rsp_ready, rsp_voltage_count, | rsp_valid & rsp_ready
//           | rsp_current_count, rsp_frame_status      |
//  csr      | csr_write_enable, csr_index, csr_write_data | csr_write_enable
//
// One byte per cycle sustained while no result waits on rsp_ready; a byte sits in the input
// register, then the frame logic and byte-wide CRC update act on it as it moves on. A result
// is registered in the result stage as its ninth byte leaves the input register. Synchronous
// reset clears control state, the CRC and the stored values. While a result waits on
// rsp_ready, one more byte is held in the input register and then req_ready drops.
module modbus_meter_reply_parser
   import mmrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_voltage_count,
   output logic [15:0] rsp_current_count,
   output logic        rsp_frame_status,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   logic [7:0]  dev_addr_ff, func_code_ff, count_byte_ff;

   logic        in_vld_ff;
   logic [7:0]  in_byte_ff;

   logic [3:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic        mism_ff, mism_in;
   logic [31:0] payload_ff, payload_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [15:0] good_volt_ff, good_volt_in;
   logic [15:0] good_curr_ff, good_curr_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_volt_ff, rsp_volt_in;
   logic [15:0] rsp_curr_ff, rsp_curr_in;
   logic        rsp_stat_ff, rsp_stat_in;

   logic        advance;
   logic        restart;
   logic [3:0]  pos_eff;
   logic [15:0] crc_eff;
   logic        mism_eff;
   logic [15:0] crc_step;
   logic [15:0] crc_rx;

   assign advance   = in_vld_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   // a position past the last byte cannot arise, but restarts the frame if it does
   assign restart  = pos_ff > POS_CRC_HI;
   assign pos_eff  = restart ? POS_ADDR : pos_ff;
   assign crc_eff  = restart ? CRC_INIT : crc_ff;
   assign mism_eff = restart ? 1'b0 : mism_ff;
   assign crc_rx   = {in_byte_ff, crc_lo_ff};

   mmrp_crc_byte u_crc (
      .crc_cur   (crc_eff),
      .data_byte (in_byte_ff),
      .crc_next  (crc_step)
   );

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      mism_in      = mism_ff;
      payload_in   = payload_ff;
      crc_lo_in    = crc_lo_ff;
      good_volt_in = good_volt_ff;
      good_curr_in = good_curr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_volt_in  = rsp_volt_ff;
      rsp_curr_in  = rsp_curr_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (advance) begin
         unique case (pos_eff)
            POS_ADDR: begin
               mism_in = mism_eff || (in_byte_ff != dev_addr_ff);
               crc_in  = crc_step;
               pos_in  = POS_FUNC;
            end
            POS_FUNC: begin
               mism_in = mism_eff || (in_byte_ff != func_code_ff);
               crc_in  = crc_step;
               pos_in  = POS_COUNT;
            end
            POS_COUNT: begin
               if (mism_eff || (in_byte_ff != count_byte_ff)) begin
                  // whole header group dropped
                  pos_in  = POS_ADDR;
                  crc_in  = CRC_INIT;
                  mism_in = 1'b0;
               end else begin
                  crc_in = crc_step;
                  pos_in = POS_VOLT_H;
               end
            end
            POS_VOLT_H, POS_VOLT_L, POS_CURR_H, POS_CURR_L: begin
               payload_in = {payload_ff[23:0], in_byte_ff};
               crc_in     = crc_step;
               pos_in     = pos_eff + 4'd1;
            end
            POS_CRC_LO: begin
               crc_lo_in = in_byte_ff;
               mism_in   = mism_eff;
               crc_in    = crc_eff;
               pos_in    = POS_CRC_HI;
            end
            POS_CRC_HI: begin
               if (crc_rx == crc_eff) begin
                  good_volt_in = payload_ff[31:16];
                  good_curr_in = payload_ff[15:0];
                  rsp_volt_in  = payload_ff[31:16];
                  rsp_curr_in  = payload_ff[15:0];
                  rsp_stat_in  = STATUS_OK;
               end else begin
                  rsp_volt_in = good_volt_ff;
                  rsp_curr_in = good_curr_ff;
                  rsp_stat_in = STATUS_CRC_BAD;
               end
               rsp_valid_in = 1'b1;
               pos_in       = POS_ADDR;
               crc_in       = CRC_INIT;
               mism_in      = 1'b0;
            end
            default: begin
               pos_in  = POS_ADDR;
               crc_in  = CRC_INIT;
               mism_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff   <= DEV_ADDR_RST;
         func_code_ff  <= FUNC_CODE_RST;
         count_byte_ff <= COUNT_BYTE_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEV_ADDR:   dev_addr_ff   <= csr_write_data;
            CSR_FUNC_CODE:  func_code_ff  <= csr_write_data;
            CSR_COUNT_BYTE: count_byte_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         pos_ff       <= POS_ADDR;
         crc_ff       <= CRC_INIT;
         mism_ff      <= 1'b0;
         good_volt_ff <= '0;
         good_curr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_vld_ff <= 1'b1;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         mism_ff      <= mism_in;
         good_volt_ff <= good_volt_in;
         good_curr_ff <= good_curr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      payload_ff  <= payload_in;
      crc_lo_ff   <= crc_lo_in;
      rsp_volt_ff <= rsp_volt_in;
      rsp_curr_ff <= rsp_curr_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_voltage_count = rsp_volt_ff;
   assign rsp_current_count = rsp_curr_ff;
   assign rsp_frame_status  = rsp_stat_ff;

endmodule

### hdl/mmrp_crc_byte.sv
// CRC-16/Modbus update over one byte, reflected, one shift per bit.
module mmrp_crc_byte
   import mmrp_pkg::*;
(
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_next
);

   always_comb begin
      logic [15:0] acc;
      acc = crc_cur ^ {8'h00, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule

### hdl/mmrp_checker.sv
// Port-level checker for the reply parser, bound to the top level.
`include "modbus_meter_reply_parser_macros.svh"

module mmrp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_voltage_count,
   input logic [15:0] rsp_current_count,
   input logic        rsp_frame_status
);

   // a stalled result stays offered
   `MMRP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp_valid dropped")

   // a stalled result keeps its payload
   `MMRP_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready,
      $stable(rsp_voltage_count) && $stable(rsp_current_count) && $stable(rsp_frame_status),
      "rsp payload changed while stalled")

   // at least nine bytes separate two results, so none follows a transfer directly
   `MMRP_ASSERT_NEXT(a_rsp_spacing, rsp_valid && rsp_ready, !rsp_valid,
      "result directly after a result transfer")

   // nothing offered straight out of reset
   `MMRP_ASSERT_NOW(a_rsp_after_reset, $past(reset), !rsp_valid, "result right after reset")

endmodule

bind modbus_meter_reply_parser mmrp_checker u_mmrp_checker (.*);
